// ===== design/tcs_pkg.sv =====
// tcs_pkg: shared constants, error codes and the decision struct of the
// tagged crossbar switch. No dependencies; used by tcs_core and the top level.
package tcs_pkg;

    // Port geometry is fixed by the per-input and per-output ports.
    localparam int NUM_INPUTS  = 4;
    localparam int NUM_OUTPUTS = 4;
    localparam int TAG_WIDTH   = 4;

    // Defaults for the top-level parameters.
    localparam int NUM_SLOTS   = 4;
    localparam int DATA_WIDTH  = 32;

    localparam int NUM_PAIRS   = NUM_INPUTS * NUM_OUTPUTS;
    localparam int SLOT_WIDTH  = 1 + TAG_WIDTH + NUM_PAIRS;
    localparam int IN_IDX_W    = $clog2(NUM_INPUTS);
    localparam int SLOT_BIT_W  = $clog2(SLOT_WIDTH);

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_DUP_TAG    = 3'd1,
        ERR_SHARED_OUT = 3'd2,
        ERR_NO_MATCH   = 3'd3,
        ERR_UNROUTED   = 3'd4
    } err_code_t;

    // Result of one switch cycle, handed from the core to the top level.
    typedef struct packed {
        logic [NUM_OUTPUTS-1:0]               out_valid;
        logic [NUM_OUTPUTS-1:0][IN_IDX_W-1:0] winner;
        logic [NUM_INPUTS-1:0]                in_ready;
        logic                                 err_hit;
        err_code_t                            err_code;
    } tcs_decision_t;

endpackage

// ===== design/tcs_core.sv =====
// tcs_core: route decode, tag match, round-robin arbitration and error check
// for one switch cycle. Pure combinational; depends on tcs_pkg.
module tcs_core #(
    parameter int NUM_SLOTS = tcs_pkg::NUM_SLOTS
) (
    input  logic [tcs_pkg::NUM_PAIRS-1:0]                        conn_mask,
    input  logic [NUM_SLOTS-1:0][tcs_pkg::SLOT_WIDTH-1:0]        route_slot,
    input  logic [tcs_pkg::NUM_OUTPUTS-1:0][tcs_pkg::IN_IDX_W-1:0] rr_ptr,
    input  logic [tcs_pkg::NUM_INPUTS-1:0]                       in_valid_mask,
    input  logic [tcs_pkg::NUM_INPUTS*tcs_pkg::TAG_WIDTH-1:0]    in_tags,
    input  logic [tcs_pkg::NUM_OUTPUTS-1:0]                      out_ready_mask,
    output tcs_pkg::tcs_decision_t                               decision
);

    localparam int NI = tcs_pkg::NUM_INPUTS;
    localparam int NO = tcs_pkg::NUM_OUTPUTS;
    localparam int TW = tcs_pkg::TAG_WIDTH;
    localparam int NP = tcs_pkg::NUM_PAIRS;
    localparam int IW = tcs_pkg::IN_IDX_W;
    localparam int PW = tcs_pkg::SLOT_BIT_W;

    logic [NP-1:0][PW-1:0]                pair_pos;
    logic [NUM_SLOTS-1:0]                 slot_vld;
    logic [NUM_SLOTS-1:0][TW-1:0]         slot_tag;
    logic [NUM_SLOTS-1:0][NI-1:0][NO-1:0] targets;
    logic                                 dup_tag;
    logic                                 shared_out;
    logic [NI-1:0]                        matched;
    logic [NI-1:0][NO-1:0]                tgt;
    logic [NO-1:0]                        win_found;
    logic [NO-1:0][IW-1:0]                win_idx;
    logic [NI-1:0]                        fire;

    // Bit position of each pair's route bit: compressed over set connectivity bits.
    always_comb begin
        logic [NP-1:0] below;
        for (int p = 0; p < NP; p++) begin
            below = '0;
            for (int q = 0; q < p; q++) begin
                below[q] = conn_mask[q];
            end
            pair_pos[p] = PW'(TW + 1) + PW'($countones(below));
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_vld[s] = route_slot[s][0];
            slot_tag[s] = route_slot[s][TW:1];
            for (int o = 0; o < NO; o++) begin
                for (int i = 0; i < NI; i++) begin
                    targets[s][i][o] = slot_vld[s] & conn_mask[o*NI + i]
                                       & route_slot[s][pair_pos[o*NI + i]];
                end
            end
        end
    end

    // Static config checks
    always_comb begin
        logic [NI-1:0] column;
        dup_tag    = 1'b0;
        shared_out = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            for (int t = s + 1; t < NUM_SLOTS; t++) begin
                if (slot_vld[s] && slot_vld[t] && slot_tag[s] == slot_tag[t]) begin
                    dup_tag = 1'b1;
                end
            end
            for (int o = 0; o < NO; o++) begin
                for (int i = 0; i < NI; i++) begin
                    column[i] = targets[s][i][o];
                end
                if ($countones(column) > 1) begin
                    shared_out = 1'b1;
                end
            end
        end
    end

    // First valid slot with a matching tag wins.
    always_comb begin
        logic [TW-1:0] tag_i;
        logic          found;
        for (int i = 0; i < NI; i++) begin
            tag_i  = in_tags[i*TW +: TW];
            found  = 1'b0;
            tgt[i] = '0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (!found && slot_vld[s] && slot_tag[s] == tag_i) begin
                    found  = 1'b1;
                    tgt[i] = targets[s][i];
                end
            end
            matched[i] = in_valid_mask[i] & found;
            if (!in_valid_mask[i]) begin
                tgt[i] = '0;
            end
        end
    end

    // Round-robin scan per output, starting at its pointer.
    always_comb begin
        logic [IW:0]   sum;
        logic [IW-1:0] cand;
        for (int o = 0; o < NO; o++) begin
            win_found[o] = 1'b0;
            win_idx[o]   = '0;
            for (int k = 0; k < NI; k++) begin
                sum = (IW+1)'(rr_ptr[o]) + (IW+1)'(k);
                if (sum >= (IW+1)'(NI)) begin
                    sum = sum - (IW+1)'(NI);
                end
                cand = sum[IW-1:0];
                if (!win_found[o] && tgt[cand][o]) begin
                    win_found[o] = 1'b1;
                    win_idx[o]   = cand;
                end
            end
        end
    end

    // Broadcast fires only when every target is won and ready.
    always_comb begin
        for (int i = 0; i < NI; i++) begin
            fire[i] = (tgt[i] != '0);
            for (int o = 0; o < NO; o++) begin
                if (tgt[i][o] && (!win_found[o] || win_idx[o] != IW'(i)
                                  || !out_ready_mask[o])) begin
                    fire[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        for (int o = 0; o < NO; o++) begin
            decision.out_valid[o] = win_found[o] & fire[win_idx[o]];
        end
        decision.winner   = win_idx;
        decision.in_ready = fire;
        decision.err_hit  = 1'b0;
        decision.err_code = tcs_pkg::ERR_NONE;
        if (dup_tag) begin
            decision.err_hit  = 1'b1;
            decision.err_code = tcs_pkg::ERR_DUP_TAG;
        end else if (shared_out) begin
            decision.err_hit  = 1'b1;
            decision.err_code = tcs_pkg::ERR_SHARED_OUT;
        end else begin
            for (int i = 0; i < NI; i++) begin
                if (!decision.err_hit) begin
                    if (in_valid_mask[i] && !matched[i]) begin
                        decision.err_hit  = 1'b1;
                        decision.err_code = tcs_pkg::ERR_NO_MATCH;
                    end else if (matched[i] && tgt[i] == '0) begin
                        decision.err_hit  = 1'b1;
                        decision.err_code = tcs_pkg::ERR_UNROUTED;
                    end
                end
            end
        end
    end

endmodule

// ===== design/tag_routed_crossbar_switch.sv =====
// tag_routed_crossbar_switch: top level of the tagged crossbar switch model.
// Holds config, round-robin pointers, sticky error and the in/out stages;
// depends on tcs_pkg and tcs_core.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------------
//   input s_  | s_valid / s_ready    | valid/tag/has-tag masks, 4 data, out ready
//   result m_ | m_valid / m_ready    | out masks, 4 data, tags, in ready, error
//   config    | cfg_wr_en            | cfg_index, cfg_wdata (21 bits)
//
// One word in and one word out per cycle while m_ready holds; a word taken on s_
// reaches m_ through the input register, then the result register.
// The rate is set by the pointer/error feedback, which closes around
// tcs_core between the input stage and the result register.
// Reset (aresetn low, sync) clears pointers, error latch, stage valids and
// config (connectivity all ones, slots zero).
// A stalled result holds the input stage; s_ready frees up as soon as the
// result register drains or is taken in the same cycle.
module tag_routed_crossbar_switch #(
    parameter int NUM_SLOTS  = tcs_pkg::NUM_SLOTS,
    parameter int DATA_WIDTH = tcs_pkg::DATA_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]        cfg_index,
    input  logic [tcs_pkg::SLOT_WIDTH-1:0]        cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [tcs_pkg::NUM_INPUTS-1:0]        s_in_valid_mask,
    input  logic [tcs_pkg::NUM_INPUTS*tcs_pkg::TAG_WIDTH-1:0] s_in_tags,
    input  logic [tcs_pkg::NUM_INPUTS-1:0]        s_in_has_tag_mask,
    input  logic [DATA_WIDTH-1:0]                 s_in_data_0,
    input  logic [DATA_WIDTH-1:0]                 s_in_data_1,
    input  logic [DATA_WIDTH-1:0]                 s_in_data_2,
    input  logic [DATA_WIDTH-1:0]                 s_in_data_3,
    input  logic [tcs_pkg::NUM_OUTPUTS-1:0]       s_out_ready_mask,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tcs_pkg::NUM_OUTPUTS-1:0]       m_out_valid_mask,
    output logic [DATA_WIDTH-1:0]                 m_out_data_0,
    output logic [DATA_WIDTH-1:0]                 m_out_data_1,
    output logic [DATA_WIDTH-1:0]                 m_out_data_2,
    output logic [DATA_WIDTH-1:0]                 m_out_data_3,
    output logic [tcs_pkg::NUM_OUTPUTS*tcs_pkg::TAG_WIDTH-1:0] m_out_tags,
    output logic [tcs_pkg::NUM_OUTPUTS-1:0]       m_out_has_tag_mask,
    output logic [tcs_pkg::NUM_INPUTS-1:0]        m_in_ready_mask,
    output logic                                  m_error_valid,
    output logic [2:0]                            m_error_code
);

    localparam int NI  = tcs_pkg::NUM_INPUTS;
    localparam int NO  = tcs_pkg::NUM_OUTPUTS;
    localparam int TW  = tcs_pkg::TAG_WIDTH;
    localparam int NP  = tcs_pkg::NUM_PAIRS;
    localparam int SW  = tcs_pkg::SLOT_WIDTH;
    localparam int IW  = tcs_pkg::IN_IDX_W;
    localparam int CIW = $clog2(NUM_SLOTS + 1);

    // Config registers
    logic [NP-1:0]                  conn_reg;
    logic [NUM_SLOTS-1:0][SW-1:0]   slot_reg;

    // Switch state
    logic [NO-1:0][IW-1:0]          ptr_reg;
    logic [NO-1:0][IW-1:0]          ptr_next;
    logic                           err_flag_reg;
    logic                           err_flag_next;
    tcs_pkg::err_code_t             err_kind_reg;
    tcs_pkg::err_code_t             err_kind_next;

    // Input stage
    logic                           stage_valid_reg;
    logic [NI-1:0]                  in_vmask_reg;
    logic [NI*TW-1:0]               in_tags_reg;
    logic [NI-1:0]                  in_htag_reg;
    logic [NI-1:0][DATA_WIDTH-1:0]  in_data_reg;
    logic [NO-1:0]                  out_rdy_reg;

    // Result register
    logic                           m_valid_reg;
    logic [NO-1:0]                  out_vmask_reg;
    logic [NO-1:0]                  out_vmask_next;
    logic [NO-1:0][DATA_WIDTH-1:0]  out_data_reg;
    logic [NO-1:0][DATA_WIDTH-1:0]  out_data_next;
    logic [NO*TW-1:0]               out_tags_reg;
    logic [NO*TW-1:0]               out_tags_next;
    logic [NO-1:0]                  out_htag_reg;
    logic [NO-1:0]                  out_htag_next;
    logic [NI-1:0]                  in_rdy_reg;

    tcs_pkg::tcs_decision_t         decision;
    logic                           advance;
    logic                           s_accept;

    // The stage moves into the result register when that register is free
    // or being drained this cycle.
    assign advance  = stage_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready  = ~stage_valid_reg | advance;
    assign s_accept = s_valid & s_ready;

    tcs_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_core (
        .conn_mask      (conn_reg),
        .route_slot     (slot_reg),
        .rr_ptr         (ptr_reg),
        .in_valid_mask  (in_vmask_reg),
        .in_tags        (in_tags_reg),
        .out_ready_mask (out_rdy_reg),
        .decision       (decision)
    );

    // Output mux and next state
    always_comb begin
        logic [IW:0] nxt;
        for (int o = 0; o < NO; o++) begin
            out_vmask_next[o]       = decision.out_valid[o];
            out_data_next[o]        = '0;
            out_tags_next[o*TW +: TW] = '0;
            out_htag_next[o]        = 1'b0;
            ptr_next[o]             = ptr_reg[o];
            nxt = (IW+1)'(decision.winner[o]) + (IW+1)'(1);
            if (nxt >= (IW+1)'(NI)) begin
                nxt = nxt - (IW+1)'(NI);
            end
            if (decision.out_valid[o]) begin
                out_data_next[o]          = in_data_reg[decision.winner[o]];
                out_tags_next[o*TW +: TW] = in_tags_reg[decision.winner[o]*TW +: TW];
                out_htag_next[o]          = in_htag_reg[decision.winner[o]];
                ptr_next[o]               = nxt[IW-1:0];
            end
        end
        err_flag_next = err_flag_reg | decision.err_hit;
        err_kind_next = (!err_flag_reg && decision.err_hit) ? decision.err_code
                                                            : err_kind_reg;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conn_reg        <= '1;
            slot_reg        <= '0;
            ptr_reg         <= '0;
            err_flag_reg    <= 1'b0;
            err_kind_reg    <= tcs_pkg::ERR_NONE;
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == '0) begin
                    conn_reg <= cfg_wdata[NP-1:0];
                end
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (cfg_index == CIW'(s + 1)) begin
                        slot_reg[s] <= cfg_wdata;
                    end
                end
            end
            if (s_accept) begin
                stage_valid_reg <= 1'b1;
            end else if (advance) begin
                stage_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg  <= 1'b1;
                ptr_reg      <= ptr_next;
                err_flag_reg <= err_flag_next;
                err_kind_reg <= err_kind_next;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_vmask_reg   <= s_in_valid_mask;
            in_tags_reg    <= s_in_tags;
            in_htag_reg    <= s_in_has_tag_mask;
            in_data_reg[0] <= s_in_data_0;
            in_data_reg[1] <= s_in_data_1;
            in_data_reg[2] <= s_in_data_2;
            in_data_reg[3] <= s_in_data_3;
            out_rdy_reg    <= s_out_ready_mask;
        end
        if (advance) begin
            out_vmask_reg <= out_vmask_next;
            out_data_reg  <= out_data_next;
            out_tags_reg  <= out_tags_next;
            out_htag_reg  <= out_htag_next;
            in_rdy_reg    <= decision.in_ready;
        end
    end

    // Error fields reflect the latch after this word, which is the state now
    // held in the latch once the word has moved to the result register.
    assign m_valid            = m_valid_reg;
    assign m_out_valid_mask   = out_vmask_reg;
    assign m_out_data_0       = out_data_reg[0];
    assign m_out_data_1       = out_data_reg[1];
    assign m_out_data_2       = out_data_reg[2];
    assign m_out_data_3       = out_data_reg[3];
    assign m_out_tags         = out_tags_reg;
    assign m_out_has_tag_mask = out_htag_reg;
    assign m_in_ready_mask    = in_rdy_reg;
    assign m_error_valid      = err_flag_reg;
    assign m_error_code       = err_kind_reg;

endmodule

// ===== test/tb_tag_routed_crossbar_switch.sv =====
// tb_tag_routed_crossbar_switch: self-checking bench for the tagged crossbar switch.
// Depends on tcs_pkg (geometry, error codes) and tag_routed_crossbar_switch;
// holds its own cycle model of the switch inside a small scoreboard class.
module tb_tag_routed_crossbar_switch;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_INPUTS  = tcs_pkg::NUM_INPUTS;
    localparam int NUM_OUTPUTS = tcs_pkg::NUM_OUTPUTS;
    localparam int TAG_WIDTH   = tcs_pkg::TAG_WIDTH;
    localparam int NUM_SLOTS   = tcs_pkg::NUM_SLOTS;
    localparam int DATA_WIDTH  = tcs_pkg::DATA_WIDTH;
    localparam int NUM_PAIRS   = tcs_pkg::NUM_PAIRS;
    localparam int SLOT_WIDTH  = tcs_pkg::SLOT_WIDTH;
    localparam int IN_IDX_W    = tcs_pkg::IN_IDX_W;
    localparam int CFG_IDX_W   = $clog2(NUM_SLOTS + 1);

    // Register map of the write port
    localparam int REG_CONN      = 0;
    localparam int REG_SLOT_BASE = 1;
    localparam int NUM_REGS      = 1 + NUM_SLOTS;

    // Tags of the directed route table
    localparam logic [TAG_WIDTH-1:0] TAG_IDENT  = 4'h0;
    localparam logic [TAG_WIDTH-1:0] TAG_BCAST  = 4'hF;
    localparam logic [TAG_WIDTH-1:0] TAG_SHIFT  = 4'h5;
    localparam logic [TAG_WIDTH-1:0] TAG_MIRROR = 4'hA;

    localparam int WORDS_PER_PHASE = 46;
    localparam int NUM_PHASES      = 12;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {SC_NO_MATCH, SC_UNROUTED, SC_DUP_TAG, SC_SHARED} err_case_t;

    // route set: element i is the output mask that input i is sent to
    typedef logic [NUM_INPUTS-1:0][NUM_OUTPUTS-1:0] route_set_t;

    typedef struct packed {
        logic [NUM_INPUTS-1:0]                 valid_mask;
        logic [NUM_INPUTS-1:0][TAG_WIDTH-1:0]  tags;
        logic [NUM_INPUTS-1:0]                 has_tag;
        logic [NUM_INPUTS-1:0][DATA_WIDTH-1:0] data;
        logic [NUM_OUTPUTS-1:0]                dest_ready;
    } switch_word_t;

    typedef struct packed {
        logic [NUM_OUTPUTS-1:0]                 out_valid;
        logic [NUM_OUTPUTS-1:0][DATA_WIDTH-1:0] data;
        logic [NUM_OUTPUTS-1:0][TAG_WIDTH-1:0]  tags;
        logic [NUM_OUTPUTS-1:0]                 has_tag;
        logic [NUM_INPUTS-1:0]                  in_ready;
        logic                                   err_valid;
        logic [2:0]                             err_code;
    } switch_result_t;

    // ------------------------------------------------------------------
    // Scoreboard: shadow config, round-robin pointers and error latch.
    // note_word() runs one switch cycle per accepted word and queues the
    // decision; check_result() compares against the oldest queued one.
    // ------------------------------------------------------------------
    class switch_scoreboard;
        logic [NUM_PAIRS-1:0]  conn;
        logic [SLOT_WIDTH-1:0] slot [NUM_SLOTS];
        logic [IN_IDX_W-1:0]   rr_ptr [NUM_OUTPUTS];
        bit                    err_flag;
        tcs_pkg::err_code_t    err_kind;
        switch_result_t        pending [$];
        int n_words, n_results, n_mismatch, n_fired;

        function new();
            conn = '1;
            foreach (slot[s]) slot[s] = '0;
            foreach (rr_ptr[o]) rr_ptr[o] = '0;
            err_flag = 1'b0;
            err_kind = tcs_pkg::ERR_NONE;
        endfunction

        function void write_reg(int idx, logic [SLOT_WIDTH-1:0] v);
            if (idx == REG_CONN) begin
                conn = v[NUM_PAIRS-1:0];
            end else if (idx >= REG_SLOT_BASE && idx < NUM_REGS) begin
                slot[idx-REG_SLOT_BASE] = v;
            end
        endfunction

        function bit slot_on(int s);
            return slot[s][0];
        endfunction

        function logic [TAG_WIDTH-1:0] slot_tag(int s);
            return slot[s][TAG_WIDTH:1];
        endfunction

        // Expand the compressed route bits of a slot; one bit is consumed
        // per connected pair, walking output-major.
        function route_set_t slot_routes(int s);
            route_set_t r;
            int pos;
            r = '0;
            pos = 1 + TAG_WIDTH;
            if (slot_on(s)) begin
                for (int o = 0; o < NUM_OUTPUTS; o++) begin
                    for (int i = 0; i < NUM_INPUTS; i++) begin
                        if (conn[o*NUM_INPUTS+i]) begin
                            if (slot[s][pos]) r[i][o] = 1'b1;
                            pos++;
                        end
                    end
                end
            end
            return r;
        endfunction

        function int lookup(logic [TAG_WIDTH-1:0] tag);
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (slot_on(s) && slot_tag(s) == tag) return s;
            end
            return -1;
        endfunction

        function void latch(tcs_pkg::err_code_t c);
            if (!err_flag) begin
                err_flag = 1'b1;
                err_kind = c;
            end
        endfunction

        function void note_word(switch_word_t w);
            route_set_t     rs [NUM_SLOTS];
            int             hit [NUM_INPUTS];
            int             win [NUM_OUTPUTS];
            bit             fire [NUM_INPUTS];
            int             cnt, idx;
            switch_result_t e;

            foreach (rs[s]) rs[s] = slot_routes(s);

            // config checks come first: duplicate tags, then shared outputs
            for (int s = 0; s < NUM_SLOTS; s++) begin
                for (int t = s + 1; t < NUM_SLOTS; t++) begin
                    if (slot_on(s) && slot_on(t) && slot_tag(s) == slot_tag(t))
                        latch(tcs_pkg::ERR_DUP_TAG);
                end
            end
            for (int s = 0; s < NUM_SLOTS; s++) begin
                for (int o = 0; o < NUM_OUTPUTS; o++) begin
                    cnt = 0;
                    for (int i = 0; i < NUM_INPUTS; i++) cnt += rs[s][i][o];
                    if (cnt > 1) latch(tcs_pkg::ERR_SHARED_OUT);
                end
            end

            for (int i = 0; i < NUM_INPUTS; i++) begin
                hit[i] = -1;
                if (w.valid_mask[i]) begin
                    hit[i] = lookup(w.tags[i]);
                    if (hit[i] < 0) latch(tcs_pkg::ERR_NO_MATCH);
                    else if (rs[hit[i]][i] == '0) latch(tcs_pkg::ERR_UNROUTED);
                end
            end

            for (int o = 0; o < NUM_OUTPUTS; o++) begin
                win[o] = -1;
                for (int k = 0; k < NUM_INPUTS && win[o] < 0; k++) begin
                    idx = (rr_ptr[o] + k) % NUM_INPUTS;
                    if (hit[idx] >= 0 && rs[hit[idx]][idx][o]) win[o] = idx;
                end
            end

            // broadcast is all-or-nothing: every target won and ready
            e = '0;
            for (int i = 0; i < NUM_INPUTS; i++) begin
                fire[i] = 1'b0;
                if (hit[i] >= 0 && rs[hit[i]][i] != '0) begin
                    fire[i] = 1'b1;
                    for (int o = 0; o < NUM_OUTPUTS; o++) begin
                        if (rs[hit[i]][i][o] && (win[o] != i || !w.dest_ready[o]))
                            fire[i] = 1'b0;
                    end
                end
                e.in_ready[i] = fire[i];
            end

            for (int o = 0; o < NUM_OUTPUTS; o++) begin
                if (win[o] >= 0 && fire[win[o]]) begin
                    e.out_valid[o] = 1'b1;
                    e.data[o]      = w.data[win[o]];
                    e.tags[o]      = w.tags[win[o]];
                    e.has_tag[o]   = w.has_tag[win[o]];
                    rr_ptr[o]      = IN_IDX_W'((win[o] + 1) % NUM_INPUTS);
                    n_fired++;
                end
            end

            e.err_valid = err_flag;
            e.err_code  = err_kind;
            pending = {pending, e};
            n_words++;
        endfunction

        function void diff(string field, logic [63:0] exp_v, logic [63:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t ns: %s mismatch, expected %h actual %h",
                         $time, field, exp_v, act_v);
                n_mismatch++;
            end
        endfunction

        function void check_result(switch_result_t a);
            switch_result_t e;
            if (pending.size() == 0) begin
                $display("%0t ns: result word with nothing pending, actual %h", $time, a);
                n_mismatch++;
            end else begin
                e = pending.pop_front();
                n_results++;
                diff("out_valid_mask", 64'(e.out_valid), 64'(a.out_valid));
                for (int o = 0; o < NUM_OUTPUTS; o++)
                    diff($sformatf("out_data_%0d", o), 64'(e.data[o]), 64'(a.data[o]));
                diff("out_tags", 64'(e.tags), 64'(a.tags));
                diff("out_has_tag_mask", 64'(e.has_tag), 64'(a.has_tag));
                diff("in_ready_mask", 64'(e.in_ready), 64'(a.in_ready));
                diff("error_valid", 64'(e.err_valid), 64'(a.err_valid));
                diff("error_code", 64'(e.err_code), 64'(a.err_code));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT hookup
    // ------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;

    logic                                cfg_wr_en;
    logic [CFG_IDX_W-1:0]                cfg_index;
    logic [SLOT_WIDTH-1:0]               cfg_wdata;

    logic                                s_valid;
    logic                                s_ready;
    logic [NUM_INPUTS-1:0]               s_in_valid_mask;
    logic [NUM_INPUTS*TAG_WIDTH-1:0]     s_in_tags;
    logic [NUM_INPUTS-1:0]               s_in_has_tag_mask;
    logic [DATA_WIDTH-1:0]               s_in_data_0, s_in_data_1, s_in_data_2, s_in_data_3;
    logic [NUM_OUTPUTS-1:0]              s_out_ready_mask;

    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [NUM_OUTPUTS-1:0]              m_out_valid_mask;
    logic [DATA_WIDTH-1:0]               m_out_data_0, m_out_data_1, m_out_data_2, m_out_data_3;
    logic [NUM_OUTPUTS*TAG_WIDTH-1:0]    m_out_tags;
    logic [NUM_OUTPUTS-1:0]              m_out_has_tag_mask;
    logic [NUM_INPUTS-1:0]               m_in_ready_mask;
    logic                                m_error_valid;
    logic [2:0]                          m_error_code;

    int send_idle_pct = 0;   // chance per cycle that the sender holds back
    int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int n_cfg_writes = 0;

    switch_scoreboard sb = new();

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    tag_routed_crossbar_switch u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_in_valid_mask    (s_in_valid_mask),
        .s_in_tags          (s_in_tags),
        .s_in_has_tag_mask  (s_in_has_tag_mask),
        .s_in_data_0        (s_in_data_0),
        .s_in_data_1        (s_in_data_1),
        .s_in_data_2        (s_in_data_2),
        .s_in_data_3        (s_in_data_3),
        .s_out_ready_mask   (s_out_ready_mask),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_valid_mask   (m_out_valid_mask),
        .m_out_data_0       (m_out_data_0),
        .m_out_data_1       (m_out_data_1),
        .m_out_data_2       (m_out_data_2),
        .m_out_data_3       (m_out_data_3),
        .m_out_tags         (m_out_tags),
        .m_out_has_tag_mask (m_out_has_tag_mask),
        .m_in_ready_mask    (m_in_ready_mask),
        .m_error_valid      (m_error_valid),
        .m_error_code       (m_error_code)
    );

    function automatic bit roll(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // Result side: m_ready moves on the falling edge, words are taken at the
    // rising edge (before any register update of that edge is visible).
    always @(negedge aclk) begin
        m_ready = !roll(recv_stall_pct);
    end

    always @(posedge aclk) begin
        switch_result_t seen;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            seen.out_valid = m_out_valid_mask;
            seen.data      = {m_out_data_3, m_out_data_2, m_out_data_1, m_out_data_0};
            seen.tags      = m_out_tags;
            seen.has_tag   = m_out_has_tag_mask;
            seen.in_ready  = m_in_ready_mask;
            seen.err_valid = m_error_valid;
            seen.err_code  = m_error_code;
            sb.check_result(seen);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic void set_idle(idle_mode_t m);
        case (m)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 53;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct = 53;
            end
            default: begin
                send_idle_pct = 17;
                recv_stall_pct = 17;
            end
        endcase
    endfunction

    // One register write per cycle; the shadow copy follows at once since
    // the switch is idle whenever config moves.
    task automatic cfg_write(int idx, logic [SLOT_WIDTH-1:0] v);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = CFG_IDX_W'(idx);
        cfg_wdata = v;
        sb.write_reg(idx, v);
        n_cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic cfg_end();
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Holds valid and payload steady until the word is taken.
    task automatic send_word(switch_word_t w);
        @(negedge aclk);
        while (roll(send_idle_pct)) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_in_valid_mask   = w.valid_mask;
        s_in_tags         = w.tags;
        s_in_has_tag_mask = w.has_tag;
        s_in_data_0       = w.data[0];
        s_in_data_1       = w.data[1];
        s_in_data_2       = w.data[2];
        s_in_data_3       = w.data[3];
        s_out_ready_mask  = w.dest_ready;
        s_valid           = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(w);
    endtask

    // Drop valid and wait until every queued result is back; the wait then
    // runs on past that to cover the two-stage pipe.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [SLOT_WIDTH-1:0] pack_slot(logic [NUM_PAIRS-1:0] c, bit on,
                                                        logic [TAG_WIDTH-1:0] tag,
                                                        route_set_t rs);
        logic [SLOT_WIDTH-1:0] v;
        int pos;
        v = '0;
        v[0] = on;
        v[TAG_WIDTH:1] = tag;
        pos = 1 + TAG_WIDTH;
        for (int o = 0; o < NUM_OUTPUTS; o++) begin
            for (int i = 0; i < NUM_INPUTS; i++) begin
                if (c[o*NUM_INPUTS+i]) begin
                    v[pos] = rs[i][o];
                    pos++;
                end
            end
        end
        return v;
    endfunction

    function automatic switch_word_t noise_word();
        switch_word_t w;
        w.valid_mask = NUM_INPUTS'($urandom_range(15, 0));
        w.tags       = (NUM_INPUTS*TAG_WIDTH)'($urandom_range(16'hFFFF, 0));
        w.has_tag    = NUM_INPUTS'($urandom_range(15, 0));
        for (int i = 0; i < NUM_INPUTS; i++) w.data[i] = $urandom;
        w.dest_ready = NUM_OUTPUTS'($urandom_range(15, 0));
        return w;
    endfunction

    // Well-formed word: every valid lane carries a tag whose slot routes it
    // somewhere; lanes with no such slot are dropped. Idle lanes keep noise tags.
    function automatic switch_word_t clean_word();
        switch_word_t w;
        route_set_t   rs;
        int           cand [$];
        w = noise_word();
        for (int i = 0; i < NUM_INPUTS; i++) begin
            if (w.valid_mask[i]) begin
                cand.delete();
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    rs = sb.slot_routes(s);
                    if (rs[i] != '0 && sb.lookup(sb.slot_tag(s)) == s) cand = {cand, s};
                end
                if (cand.size() == 0) w.valid_mask[i] = 1'b0;
                else w.tags[i] = sb.slot_tag(cand[$urandom_range(cand.size()-1, 0)]);
            end
        end
        if (roll(65)) w.dest_ready = '1;
        return w;
    endfunction

    function automatic switch_word_t dword(logic [3:0] vm, logic [15:0] tags,
                                           logic [3:0] ready);
        switch_word_t w;
        w = noise_word();
        w.valid_mask = vm;
        w.tags       = tags;
        w.dest_ready = ready;
        return w;
    endfunction

    // Directed table: identity, input 0 broadcast, rotate by one, mirror.
    // No slot ever sends two inputs to one output, so it raises no error.
    task automatic load_directed_config();
        route_set_t ident, bcast, shift, mirror;
        ident = '0;
        bcast = '0;
        shift = '0;
        mirror = '0;
        for (int i = 0; i < NUM_INPUTS; i++) begin
            ident[i][i] = 1'b1;
            shift[i][(i+1)%NUM_OUTPUTS] = 1'b1;
            mirror[i][NUM_OUTPUTS-1-i] = 1'b1;
        end
        bcast[0] = '1;
        cfg_write(REG_CONN, '1);
        cfg_write(REG_SLOT_BASE + 0, pack_slot('1, 1'b1, TAG_IDENT, ident));
        cfg_write(REG_SLOT_BASE + 1, pack_slot('1, 1'b1, TAG_BCAST, bcast));
        cfg_write(REG_SLOT_BASE + 2, pack_slot('1, 1'b1, TAG_SHIFT, shift));
        cfg_write(REG_SLOT_BASE + 3, pack_slot('1, 1'b1, TAG_MIRROR, mirror));
        cfg_end();
    endtask

    // Random table with distinct tags and at most one input per output in
    // each slot, so the only errors left are those the words bring.
    task automatic load_clean_config(logic [NUM_PAIRS-1:0] c);
        bit                   used [1<<TAG_WIDTH];
        logic [TAG_WIDTH-1:0] tag;
        route_set_t           rs;
        int                   pick;
        foreach (used[t]) used[t] = 1'b0;
        cfg_write(REG_CONN, SLOT_WIDTH'(c));
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (roll(85)) begin
                do tag = TAG_WIDTH'($urandom_range((1<<TAG_WIDTH)-1, 0)); while (used[tag]);
                used[tag] = 1'b1;
                rs = '0;
                for (int o = 0; o < NUM_OUTPUTS; o++) begin
                    pick = $urandom_range(NUM_INPUTS-1, 0);
                    if (roll(80) && c[o*NUM_INPUTS+pick]) rs[pick][o] = 1'b1;
                end
                cfg_write(REG_SLOT_BASE + s, pack_slot(c, 1'b1, tag, rs));
            end else begin
                cfg_write(REG_SLOT_BASE + s, '0);
            end
        end
        cfg_end();
    endtask

    // ------------------------------------------------------------------
    // Directed part: field extremes, arbitration, broadcast blocking, then
    // the four error cases in a seed-dependent order (the latch keeps only
    // the first, so different seeds land on different codes).
    // ------------------------------------------------------------------
    task automatic run_directed();
        switch_word_t w;
        err_case_t    order [4];
        int           j;
        err_case_t    tmp;

        set_idle(IDLE_NONE);
        load_directed_config();

        w = dword(4'h0, 16'hFFFF, 4'h0);   // nothing valid, nothing ready
        w.data = '0;
        w.has_tag = '0;
        send_word(w);
        w = dword(4'hF, 16'h0000, 4'hF);   // all lanes straight through
        w.data = '1;
        w.has_tag = '1;
        send_word(w);
        send_word(dword(4'hF, 16'h0000, 4'h0));       // no output ready
        send_word(dword(4'h1, 16'h000F, 4'hF));       // lone broadcast
        repeat (4) send_word(dword(4'hF, 16'h000F, 4'hF));  // broadcast vs lanes
        send_word(dword(4'hF, 16'h5555, 4'hA));       // rotate, half ready
        send_word(dword(4'hF, 16'hAAAA, 4'hF));       // mirror
        send_word(dword(4'hF, 16'hA50F, 4'hF));       // one lane per slot
        send_word(dword(4'hF, 16'h000F, 4'h7));       // broadcast blocked on out 3
        settle();

        order = '{SC_NO_MATCH, SC_UNROUTED, SC_DUP_TAG, SC_SHARED};
        for (int i = 3; i > 0; i--) begin
            j = $urandom_range(i, 0);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end

        foreach (order[k]) begin
            case (order[k])
                SC_NO_MATCH: begin
                    // lane 3 tag matches no slot and drops out of arbitration
                    send_word(dword(4'hF, 16'h3000, 4'hF));
                end
                SC_UNROUTED: begin
                    // lane 1 hits the broadcast slot, which only routes lane 0
                    send_word(dword(4'h3, 16'h00F0, 4'hF));
                end
                SC_DUP_TAG: begin
                    settle();
                    cfg_write(REG_SLOT_BASE + 3, pack_slot('1, 1'b1, TAG_IDENT, '0));
                    cfg_end();
                    send_word(dword(4'hF, 16'h0000, 4'hF));
                    send_word(dword(4'hF, 16'hAAAA, 4'hF));
                    settle();
                    load_directed_config();
                end
                default: begin
                    // all-ones slot: valid, tag F, every pair routed
                    settle();
                    cfg_write(REG_SLOT_BASE + 1, '1);
                    cfg_end();
                    send_word(dword(4'hF, 16'h000F, 4'hF));
                    settle();
                    load_directed_config();
                end
            endcase
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Random part: phases rotate through the idle modes; each phase loads
    // a new table, mostly well-formed, once raw noise and once with the
    // connectivity fully cleared. Words are mostly well-formed too.
    // ------------------------------------------------------------------
    task automatic run_random();
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_idle(idle_mode_t'(p % 4));
            settle();
            if (p == 3) begin
                // write past the last register: must leave the table alone
                cfg_write(NUM_REGS + $urandom_range(2, 0), SLOT_WIDTH'($urandom));
            end
            if (p == 9) begin
                cfg_write(REG_CONN, SLOT_WIDTH'($urandom));
                for (int s = 0; s < NUM_SLOTS; s++)
                    cfg_write(REG_SLOT_BASE + s, SLOT_WIDTH'($urandom));
                cfg_end();
            end else if (p == 10) begin
                load_clean_config('0);
            end else if (p % 3 == 0) begin
                load_clean_config('1);
            end else begin
                load_clean_config(NUM_PAIRS'($urandom));
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (roll(2)) settle();
                send_word(roll(85) ? clean_word() : noise_word());
            end
        end
        settle();
    endtask

    initial begin
        int guard;
        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_in_valid_mask   = '0;
        s_in_tags         = '0;
        s_in_has_tag_mask = '0;
        s_in_data_0       = '0;
        s_in_data_1       = '0;
        s_in_data_2       = '0;
        s_in_data_3       = '0;
        s_out_ready_mask  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        run_directed();
        run_random();

        guard = 0;
        while (sb.pending.size() != 0 && guard < 2000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (sb.pending.size() != 0) begin
            $display("%0t ns: %0d result words never arrived", $time, sb.pending.size());
            sb.n_mismatch++;
        end

        $display("Run summary: %0d words switched over %0d register writes, %0d results checked",
                 sb.n_words, n_cfg_writes, sb.n_results);
        $display("  %0d output tokens forwarded; sticky error latched as %s",
                 sb.n_fired, sb.err_kind.name());
        if (sb.n_mismatch == 0) begin
            $display("tag_routed_crossbar_switch test passed");
        end else begin
            $display("tag_routed_crossbar_switch test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #400000;
        $display("tag_routed_crossbar_switch test failed");
        $finish;
    end

endmodule
